/* design/bsc_pkg.sv */
// Shared types and constants for the Bhaskara sine/cosine pipeline.
package bsc_pkg;

	typedef enum logic [1:0] {
		ACT_SIN16 = 2'd0,
		ACT_COS16 = 2'd1,
		ACT_SIN8  = 2'd2,
		ACT_COS8  = 2'd3
	} action_t;

	localparam logic [14:0] HALF_MAX  = 15'h7FFF;
	localparam logic [16:0] NUM_SCALE = 17'd131068;     // 4 * 0x7FFF
	localparam logic [30:0] DEN_BASE  = 31'd1342095361;
	localparam logic [15:0] QUARTER16 = 16'h4000;
	localparam logic [7:0]  QUARTER8  = 8'd64;
	localparam logic [16:0] OFFSET8   = 17'd32895;      // 0x7FFF + 128

	localparam int QBITS          = 15;
	localparam int BITS_PER_STAGE = 3;
	localparam int DIV_STAGES     = QBITS / BITS_PER_STAGE;

	// One item in flight through the divider stages.
	typedef struct packed {
		logic        valid;
		logic        neg;
		logic        eight;
		logic [30:0] den;
		logic [30:0] rem;
		logic [14:0] low;
		logic [14:0] q;
	} div_t;

endpackage

/* design/bsc_prep.sv */
// Angle selection, half-turn fold, Bhaskara product and divider setup (two stages).
module bsc_prep (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  bsc_pkg::action_t  action,
	input  logic [15:0]       angle,
	output bsc_pkg::div_t     out_s2
);
	import bsc_pkg::*;

	logic [15:0] ang16;
	logic [7:0]  ang8;
	logic [14:0] t;
	logic [29:0] p_full;
	logic [44:0] num;

	logic        valid_s1;
	logic        neg_s1;
	logic        eight_s1;
	logic [27:0] p_s1;

	always_comb begin
		ang8 = angle[7:0];
		case (action)
			ACT_SIN16: ang16 = angle;
			ACT_COS16: ang16 = angle + QUARTER16;
			ACT_SIN8:  ang16 = {ang8, ang8};
			ACT_COS8: begin
				ang8  = angle[7:0] + QUARTER8;
				ang16 = {ang8, ang8};
			end
			default:   ang16 = angle;
		endcase
		// fold the second half-turn: 0xFFFF - a equals ~a there
		t      = ang16[15] ? ~ang16[14:0] : ang16[14:0];
		p_full = 30'(t) * 30'(HALF_MAX - t);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			neg_s1   <= ang16[15];
			eight_s1 <= action[1];
			p_s1     <= p_full[27:0];
		end
	end

	assign num = 45'(p_s1) * 45'(NUM_SCALE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_s2 <= '0;
		end else if (en) begin
			out_s2.valid <= valid_s1;
			out_s2.neg   <= neg_s1;
			out_s2.eight <= eight_s1;
			out_s2.den   <= DEN_BASE - 31'(p_s1);
			// quotient fits 15 bits, so the top part already sits below den
			out_s2.rem   <= {1'b0, num[44:15]};
			out_s2.low   <= num[14:0];
			out_s2.q     <= '0;
		end
	end

endmodule

/* design/bsc_div_stage.sv */
// One registered stage of the restoring divider, three quotient bits per stage.
module bsc_div_stage (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  bsc_pkg::div_t in_d,
	output bsc_pkg::div_t out_d
);
	import bsc_pkg::*;

	div_t st;

	always_comb begin
		logic [31:0] trial;
		logic        ge;
		st = in_d;
		for (int i = 0; i < BITS_PER_STAGE; i++) begin
			trial  = {st.rem, st.low[14]};
			ge     = (trial >= {1'b0, st.den});
			st.rem = ge ? 31'(trial - {1'b0, st.den}) : trial[30:0];
			st.q   = {st.q[13:0], ge};
			st.low = {st.low[13:0], 1'b0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_d <= '0;
		end else if (en) begin
			out_d <= st;
		end
	end

endmodule

/* design/bsc_post.sv */
// Sign restore, 8-bit offset and saturation, and the output register.
module bsc_post (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  bsc_pkg::div_t in_d,
	output logic          out_valid,
	output logic [15:0]   value
);
	import bsc_pkg::*;

	logic [15:0] mag;
	logic [15:0] s16;
	logic [16:0] v17;
	logic [7:0]  b8;

	always_comb begin
		mag = {1'b0, in_d.q};
		s16 = in_d.neg ? (16'd0 - mag) : mag;
		v17 = {s16[15], s16} + OFFSET8;
		// clamp at 0xFFFF before keeping the top byte
		b8  = v17[16] ? 8'hFF : v17[15:8];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= in_d.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			value <= in_d.eight ? {8'h00, b8} : s16;
		end
	end

endmodule

/* design/bhaskara_sine_cosine_unit_core.sv */
// Bhaskara sine/cosine unit: takes one item per clock while the output is not held
// and returns one result per item, in order. The pipeline has two stages for angle
// fold and the two multiplications, five divider stages of three quotient bits each,
// and one output stage; throughput is one item every cycle, set by this fully
// pipelined divider. When the output item is held by m_tready low, every stage
// freezes and s_tready drops, so nothing is lost or repeated. Input s_tuser carries
// the operation, s_tdata the angle; m_tdata carries the result, signed for 16-bit actions.
module bhaskara_sine_cosine_unit_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [15:0] angle
	input  logic [1:0]  s_tuser,   // [1:0] action
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata    // [15:0] value
);
	import bsc_pkg::*;

	logic    en;
	action_t action;
	div_t    stage_d [DIV_STAGES+1];

	// advance whenever the output slot is free or being taken
	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;
	assign action   = action_t'(s_tuser);

	bsc_prep u_prep (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (s_tvalid),
		.action   (action),
		.angle    (s_tdata),
		.out_s2   (stage_d[0])
	);

	for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
		bsc_div_stage u_div (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.in_d   (stage_d[g]),
			.out_d  (stage_d[g+1])
		);
	end

	bsc_post u_post (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_d      (stage_d[DIV_STAGES]),
		.out_valid (m_tvalid),
		.value     (m_tdata)
	);

endmodule

/* sim/tb_bhaskara_sine_cosine_unit_core.sv */
// Testbench for bhaskara_sine_cosine_unit_core: random and directed angles, checked in order.
`timescale 1ns / 100ps

module tb_bhaskara_sine_cosine_unit_core;
	import bsc_pkg::*;

	localparam int          N_RANDOM     = 1950;
	localparam int          CYCLE_LIMIT  = 200000;
	localparam int          IDLE_PCT     = 26;
	localparam int          HOLDOFF_AT   = 400;
	localparam int          HOLDOFF_LEN  = 300;
	localparam int          QUIET_FROM   = 900;
	localparam int          QUIET_TO     = 1300;
	localparam int          DRAIN_AT     = 1500;
	localparam int          TAIL_CYCLES  = 16;
	localparam logic [31:0] SINE_HALF    = 32'h7FFF;
	localparam logic [63:0] SINE_NUM_K   = 64'd131068;
	localparam logic [31:0] SINE_DEN_K   = 32'd1342095361;
	localparam logic [15:0] QTR_TURN16   = 16'h4000;
	localparam logic [7:0]  QTR_TURN8    = 8'd64;
	localparam int          BYTE_STRETCH = 257;
	localparam int          BYTE_OFFSET  = 32'h7FFF + 128;
	localparam int          BYTE_CLAMP   = 32'hFFFF;
	localparam logic [15:0] EDGE_ANGLES [6] = '{16'h0000, 16'h7FFF, 16'h8000, 16'hFFFF,
		16'h4000, 16'hC000};

	typedef struct {
		action_t     act;
		logic [15:0] angle;
		bit          drain;
	} angle_req_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata = 16'h0000;
	action_t     s_tuser = ACT_SIN16;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;

	angle_req_t  pending_angles[$];
	logic [15:0] expected_values[$];
	int          n_accepted = 0;
	int          n_errors = 0;
	int          n_cycles = 0;
	int          holdoff_left = 0;
	bit          holdoff_done = 1'b0;

	bhaskara_sine_cosine_unit_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	// Signed 16-bit sine of a 16-bit angle, rational approximation in integers.
	function automatic int bhaskara_sine16(logic [15:0] ang);
		logic [31:0] t;
		logic [31:0] p;
		logic [63:0] num;
		logic [31:0] den;
		logic [31:0] q;
		bit          neg;
		t = {16'h0000, ang};
		neg = 1'b0;
		// fold the second half turn onto the first
		if (t > SINE_HALF) begin
			t = 32'hFFFF - t;
			neg = 1'b1;
		end
		p = t * (SINE_HALF - t);
		num = {32'h0, p} * SINE_NUM_K;
		den = SINE_DEN_K - p;
		q = 32'(num / {32'h0, den}) & SINE_HALF;
		return neg ? -int'(q) : int'(q);
	endfunction

	function automatic logic [15:0] bhaskara_sine8(logic [7:0] ang8);
		int v;
		v = bhaskara_sine16(16'(int'(ang8) * BYTE_STRETCH)) + BYTE_OFFSET;
		if (v > BYTE_CLAMP)
			v = BYTE_CLAMP;
		return {8'h00, 8'(v >> 8)};
	endfunction

	function automatic logic [15:0] bhaskara_value(action_t act, logic [15:0] angle);
		case (act)
			ACT_SIN16: return 16'(bhaskara_sine16(angle));
			ACT_COS16: return 16'(bhaskara_sine16(angle + QTR_TURN16));
			ACT_SIN8:  return bhaskara_sine8(angle[7:0]);
			default:   return bhaskara_sine8(angle[7:0] + QTR_TURN8);
		endcase
	endfunction

	task automatic note_mismatch(string what, logic [15:0] exp_v, logic [15:0] got_v);
		n_errors++;
		if (n_errors <= 10)
			$display("mismatch at %0t: %s expected %h got %h", $realtime, what, exp_v, got_v);
	endtask

	function automatic bit quiet_stretch();
		return n_accepted >= QUIET_FROM && n_accepted < QUIET_TO;
	endfunction

	initial begin
		forever #5 clk = ~clk;
	end

	// Driver: present the next pending item when the bus is free, with random idle gaps.
	always @(posedge clk or negedge arst_n) begin
		bit go;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= 16'h0000;
			s_tuser <= ACT_SIN16;
		end else begin
			if (s_tvalid && s_tready) begin
				expected_values.push_back(bhaskara_value(s_tuser, s_tdata));
				n_accepted <= n_accepted + 1;
			end
			if (!s_tvalid || s_tready) begin
				go = pending_angles.size() != 0;
				// hold a drain item until every result is back
				if (go && pending_angles[0].drain &&
						(expected_values.size() != 0 || (s_tvalid && s_tready)))
					go = 1'b0;
				if (go && !quiet_stretch() && $urandom_range(99) < IDLE_PCT)
					go = 1'b0;
				if (go) begin
					s_tvalid <= 1'b1;
					s_tdata <= pending_angles[0].angle;
					s_tuser <= pending_angles[0].act;
					void'(pending_angles.pop_front());
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Receiver ready, with one long hold-off to back the pipeline up.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			holdoff_left <= 0;
			holdoff_done <= 1'b0;
		end else if (!holdoff_done && n_accepted >= HOLDOFF_AT) begin
			holdoff_left <= HOLDOFF_LEN;
			holdoff_done <= 1'b1;
			m_tready <= 1'b0;
		end else if (holdoff_left > 0) begin
			holdoff_left <= holdoff_left - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= quiet_stretch() || $urandom_range(99) >= IDLE_PCT;
		end
	end

	// Monitor: compare each result with the oldest prediction.
	always @(posedge clk) begin
		logic [15:0] exp_v;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_values.size() == 0) begin
				note_mismatch("unexpected value", 16'h0000, m_tdata);
			end else begin
				exp_v = expected_values.pop_front();
				if (m_tdata !== exp_v)
					note_mismatch("value", exp_v, m_tdata);
			end
		end
	end

	always @(posedge clk) begin
		n_cycles <= n_cycles + 1;
		if (n_cycles == CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	initial begin
		angle_req_t req;
		logic [15:0] directed [6];
		directed = '{16'h0000, 16'h7FFF, 16'h8000, 16'hFFFF, 16'hC000, 16'hFF40};
		for (int a = 0; a < 4; a++) begin
			foreach (directed[i]) begin
				req.act = action_t'(a);
				req.angle = directed[i];
				req.drain = 1'b0;
				pending_angles.push_back(req);
			end
		end
		for (int n = 0; n < N_RANDOM; n++) begin
			req.act = action_t'($urandom_range(3));
			if ($urandom_range(9) == 0)
				req.angle = EDGE_ANGLES[$urandom_range(5)] + 16'($urandom_range(2)) - 16'd1;
			else
				req.angle = 16'($urandom);
			// pause the sender after the directed part and once mid-run
			req.drain = (n == 0) || (n == DRAIN_AT);
			pending_angles.push_back(req);
		end

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_angles.size() != 0 || s_tvalid || expected_values.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (n_errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
